// ===== rtl/wrb_pkg.sv =====
// Shared types, constants and the arctangent table for the waypoint range/bearing block.
// No dependencies.
package wrb_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    // CORDIC datapath: Q20.8 coordinates, headroom for gain and vector length
    localparam int DW = 28;
    localparam int PW = DW + 18;
    localparam logic signed [17:0] INV_GAIN = 18'sd39797;
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << 23;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IW-1:0] REG_ROTATION = 2'd2;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [17:0] DIST_MAX  = 18'h3FFFF;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic               target_is_local;
        logic signed [15:0] current_x;
        logic signed [15:0] current_y;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] global_x;
        logic signed [15:0] global_y;
        logic        [17:0] distance;
        logic        [15:0] bearing;
    } out_word_t;

    // global target and current position, between the two CORDIC units
    typedef struct packed {
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } polar_in_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic        [31:0]   z;
    } cordic_t;

    // atan(2^-i), full turn = 2^32
    function automatic logic [31:0] atan_angle(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/wrb_xform.sv =====
// Plot-to-global transform: quadrant pre-rotation, rotation CORDIC, gain, offset, saturation.
// Uses wrb_pkg.
module wrb_xform (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  wrb_pkg::in_word_t   in_word,
    input  logic signed [15:0]  origin_x,
    input  logic signed [15:0]  origin_y,
    input  logic [15:0]         rotation,
    output logic                out_valid,
    output wrb_pkg::polar_in_t  out_item
);
    import wrb_pkg::*;

    logic [NSTG:0]      v_reg;
    cordic_t            c_reg [0:NSTG];
    in_word_t           w_reg [0:NSTG];

    logic               m_valid_reg;
    logic signed [PW-1:0] mx_reg, my_reg;
    in_word_t           m_word_reg;

    logic               o_valid_reg;
    polar_in_t          o_item_reg;

    // stage 0: snap angle to nearest quarter turn
    logic [31:0]        ang;
    logic [1:0]         quad;
    logic signed [DW-1:0] x0, y0;
    cordic_t            c0_next;

    always_comb
    begin
        ang  = {rotation, 16'h0000};
        quad = ang[31:30] + {1'b0, ang[29]};
        x0   = DW'(in_word.target_x) <<< 8;
        y0   = DW'(in_word.target_y) <<< 8;
        c0_next.z = ang - {quad, 30'b0};
        case (quad)
            2'd1:
            begin
                c0_next.x = -y0;
                c0_next.y = x0;
            end
            2'd2:
            begin
                c0_next.x = -x0;
                c0_next.y = -y0;
            end
            2'd3:
            begin
                c0_next.x = y0;
                c0_next.y = -x0;
            end
            default:
            begin
                c0_next.x = x0;
                c0_next.y = y0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= c0_next;
            w_reg[0] <= in_word;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stage
            cordic_t c_next;
            always_comb
            begin
                if (!c_reg[k].z[31])
                begin
                    c_next.x = c_reg[k].x - (c_reg[k].y >>> k);
                    c_next.y = c_reg[k].y + (c_reg[k].x >>> k);
                    c_next.z = c_reg[k].z - atan_angle(k);
                end
                else
                begin
                    c_next.x = c_reg[k].x + (c_reg[k].y >>> k);
                    c_next.y = c_reg[k].y - (c_reg[k].x >>> k);
                    c_next.z = c_reg[k].z + atan_angle(k);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k+1] <= 1'b0;
                else if (en)
                    v_reg[k+1] <= v_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_reg[k+1] <= c_next;
                    w_reg[k+1] <= w_reg[k];
                end
            end
        end
    endgenerate

    // gain removal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= v_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg     <= PW'(c_reg[NSTG].x) * PW'(INV_GAIN);
            my_reg     <= PW'(c_reg[NSTG].y) * PW'(INV_GAIN);
            m_word_reg <= w_reg[NSTG];
        end
    end

    // round, offset, saturate; global targets pass through
    logic [PW-1:0]       rx_sum, ry_sum;
    logic signed [22:0]  sx, sy;
    polar_in_t           o_next;

    function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
        logic signed [15:0] r;
        if (v > 23'sd32767)
            r = 16'sh7FFF;
        else if (v < -23'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    always_comb
    begin
        rx_sum = mx_reg + ROUND_HALF;
        ry_sum = my_reg + ROUND_HALF;
        sx = 23'($signed(rx_sum[PW-1:24])) + 23'(origin_x);
        sy = 23'($signed(ry_sum[PW-1:24])) + 23'(origin_y);
        o_next.cx = m_word_reg.current_x;
        o_next.cy = m_word_reg.current_y;
        if (m_word_reg.target_is_local)
        begin
            o_next.gx = sat16(sx);
            o_next.gy = sat16(sy);
        end
        else
        begin
            o_next.gx = m_word_reg.target_x;
            o_next.gy = m_word_reg.target_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            o_item_reg <= o_next;
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_item_reg;

endmodule

// ===== rtl/wrb_polar.sv =====
// Range and bearing: vectoring CORDIC, gain removal, rounding and clamping.
// Uses wrb_pkg.
module wrb_polar (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  wrb_pkg::polar_in_t  in_item,
    output logic                out_valid,
    output wrb_pkg::out_word_t  out_word
);
    import wrb_pkg::*;

    logic [NSTG:0]      v_reg;
    logic [NSTG:0]      zero_reg;
    cordic_t            c_reg  [0:NSTG];
    polar_in_t          p_reg  [0:NSTG];

    logic               m_valid_reg;
    logic               m_zero_reg;
    logic signed [PW-1:0] md_reg;
    logic [31:0]        m_z_reg;
    polar_in_t          m_item_reg;

    logic               o_valid_reg;
    out_word_t          o_word_reg;

    // stage 0: difference vector, fold into right half plane
    logic signed [16:0]   dx, dy;
    logic signed [DW-1:0] x0, y0;
    cordic_t              c0_next;

    always_comb
    begin
        dx = 17'(in_item.gx) - 17'(in_item.cx);
        dy = 17'(in_item.gy) - 17'(in_item.cy);
        x0 = DW'(dx) <<< 8;
        y0 = DW'(dy) <<< 8;
        if (x0[DW-1])
        begin
            c0_next.x = -x0;
            c0_next.y = -y0;
            c0_next.z = HALF_TURN;
        end
        else
        begin
            c0_next.x = x0;
            c0_next.y = y0;
            c0_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0]    <= c0_next;
            p_reg[0]    <= in_item;
            zero_reg[0] <= (dx == '0) && (dy == '0);
        end
    end

    genvar k;
    generate
        for (k = 0; k < NSTG; k++)
        begin : g_stage
            cordic_t c_next;
            always_comb
            begin
                if (!c_reg[k].y[DW-1])
                begin
                    c_next.x = c_reg[k].x + (c_reg[k].y >>> k);
                    c_next.y = c_reg[k].y - (c_reg[k].x >>> k);
                    c_next.z = c_reg[k].z + atan_angle(k);
                end
                else
                begin
                    c_next.x = c_reg[k].x - (c_reg[k].y >>> k);
                    c_next.y = c_reg[k].y + (c_reg[k].x >>> k);
                    c_next.z = c_reg[k].z - atan_angle(k);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k+1] <= 1'b0;
                else if (en)
                    v_reg[k+1] <= v_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_reg[k+1]    <= c_next;
                    p_reg[k+1]    <= p_reg[k];
                    zero_reg[k+1] <= zero_reg[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= v_reg[NSTG];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg     <= PW'(c_reg[NSTG].x) * PW'(INV_GAIN);
            m_z_reg    <= c_reg[NSTG].z;
            m_zero_reg <= zero_reg[NSTG];
            m_item_reg <= p_reg[NSTG];
        end
    end

    logic [PW-1:0]       d_sum;
    logic signed [21:0]  d_rnd;
    logic [31:0]         z_rnd;
    out_word_t           o_next;

    always_comb
    begin
        d_sum = md_reg + ROUND_HALF;
        d_rnd = $signed(d_sum[PW-1:24]);
        z_rnd = m_z_reg + 32'h0000_8000;
        o_next.global_x = m_item_reg.gx;
        o_next.global_y = m_item_reg.gy;
        if (m_zero_reg || d_rnd[21])
            o_next.distance = '0;
        else if (d_rnd > $signed({4'b0, DIST_MAX}))
            o_next.distance = DIST_MAX;
        else
            o_next.distance = d_rnd[17:0];
        if (m_zero_reg)
            o_next.bearing = '0;
        else
            o_next.bearing = z_rnd[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            o_word_reg <= o_next;
    end

    assign out_valid = o_valid_reg;
    assign out_word  = o_word_reg;

endmodule

// ===== rtl/waypoint_range_bearing_top.sv =====
// Top level of the waypoint range/bearing block: config registers and pipeline control.
// Uses wrb_pkg, wrb_xform and wrb_polar.
//
//  channel | signals                              | word
//  --------+--------------------------------------+-------------------------------
//  in      | in_valid, in_stall (out), in_word    | target, local flag, position
//  out     | out_valid, out_stall (in), out_word  | global target, range, bearing
//  cfg     | cfg_we, cfg_index, cfg_data          | origin x/y, plot rotation
//
// One word enters per cycle while in_stall is low. Each CORDIC unit has a fold
// stage, NSTG micro-rotation stages, a gain multiply stage and a round/saturate
// stage; the last is the output register.
// rst_n clears all valid bits and resets the config registers to zero; the datapath registers are not reset.
// The whole pipe advances together whenever the output word is empty or taken,
// so a held output freezes every stage, bubbles included, in place.
module waypoint_range_bearing_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  wrb_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output wrb_pkg::out_word_t            out_word,
    input  logic                          cfg_we,
    input  logic [wrb_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [wrb_pkg::CFG_DW-1:0]    cfg_data
);
    import wrb_pkg::*;

    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic [15:0]        rotation_reg;

    logic               en;
    logic               mid_valid;
    polar_in_t          mid_item;

    // index 3 is not a register: writes fall through the default arm
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            rotation_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                REG_ROTATION: rotation_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // advance when the output slot is free or being drained this cycle
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    wrb_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_word   (in_word),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .rotation  (rotation_reg),
        .out_valid (mid_valid),
        .out_item  (mid_item)
    );

    wrb_polar u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_valid),
        .in_item   (mid_item),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

// ===== verif/testbench.sv =====
// Testbench for waypoint_range_bearing_top: directed and random words, bit-exact CORDIC predictor.
// Depends on rtl/wrb_pkg.sv and rtl/waypoint_range_bearing_top.sv.
`timescale 1ns / 100ps

module testbench;
    import wrb_pkg::*;

    localparam int LATENCY = 2 * NSTG + 6;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_word;
    logic cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    waypoint_range_bearing_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor copy of the plot registers
    logic [15:0] org_x, org_y, plot_rot;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        failures = 0;
    int        idle_cycles = 0;
    bit        timed_out = 0;
    bit        hold_rx = 0;      // long receiver hold-off request
    int        hold_left = 0;

    // floor shift of a signed value
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // drop gain and the eight extra fraction bits, round half up
    function automatic longint unscale(longint v);
        return floor_shr(v * 39797 + (longint'(1) << 23), 24);
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic out_word_t predict_fix(in_word_t w);
        out_word_t r;
        longint gx, gy, x, y, t, dx, dy, range_v;
        logic [31:0] z, ang, q;
        gx = w.target_x;
        gy = w.target_y;
        if (w.target_is_local) begin
            x = longint'(w.target_x) * 256;
            y = longint'(w.target_y) * 256;
            ang = {plot_rot, 16'h0};
            q = ((ang + 32'h2000_0000) >> 30) & 32'd3;
            z = ang - q * 32'h4000_0000;
            if (q == 1) begin t = x; x = -y; y = t; end
            else if (q == 2) begin x = -x; y = -y; end
            else if (q == 3) begin t = x; x = y; y = -t; end
            for (int i = 0; i < NSTG; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (!z[31]) begin x -= dx; y += dy; z -= atan_angle(i); end
                else begin x += dx; y -= dy; z += atan_angle(i); end
            end
            gx = clamp16(unscale(x) + longint'($signed(org_x)));
            gy = clamp16(unscale(y) + longint'($signed(org_y)));
        end
        x = (gx - longint'(w.current_x)) * 256;
        y = (gy - longint'(w.current_y)) * 256;
        z = 0;
        if (x == 0 && y == 0) begin
            range_v = 0;
        end else begin
            if (x < 0) begin x = -x; y = -y; z = HALF_TURN; end
            for (int i = 0; i < NSTG; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (y >= 0) begin x += dx; y -= dy; z += atan_angle(i); end
                else begin x -= dx; y += dy; z -= atan_angle(i); end
            end
            range_v = unscale(x);
            if (range_v < 0) range_v = 0;
            if (range_v > 262143) range_v = 262143;
            z = z + 32'h8000;
        end
        r.global_x = gx[15:0];
        r.global_y = gy[15:0];
        r.distance = range_v[17:0];
        r.bearing  = z[31:16];
        return r;
    endfunction

    // sender: sometimes waits a random gap between words, holds each until taken
    int tx_gap = 0;
    always @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            expected_words.push_back(predict_fix(in_word));
            if (pending_words.size() > 0 && $urandom_range(0, 3) == 0)
                tx_gap = $urandom_range(0, 19);
            else
                tx_gap = 0;
        end
        if (!(in_valid && in_stall)) begin
            if (tx_gap == 0 && pending_words.size() > 0) begin
                in_valid <= 1'b1;
                in_word  <= pending_words.pop_front();
            end else begin
                in_valid <= 1'b0;
                if (tx_gap > 0) tx_gap = tx_gap - 1;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    int rx_gap = 0;
    always @(posedge clk)
    begin
        if (out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                failures++;
            end else begin
                out_word_t e;
                e = expected_words.pop_front();
                if (out_word.global_x !== e.global_x) begin
                    $error("global_x exp %0d got %0d", e.global_x, out_word.global_x);
                    failures++;
                end
                if (out_word.global_y !== e.global_y) begin
                    $error("global_y exp %0d got %0d", e.global_y, out_word.global_y);
                    failures++;
                end
                if (out_word.distance !== e.distance) begin
                    $error("distance exp %0d got %0d", e.distance, out_word.distance);
                    failures++;
                end
                if (out_word.bearing !== e.bearing) begin
                    $error("bearing exp %0d got %0d", e.bearing, out_word.bearing);
                    failures++;
                end
            end
            if ($urandom_range(0, 3) == 0) rx_gap = $urandom_range(0, 19);
        end
        if (hold_rx && hold_left == 0) begin
            hold_left = 200;
            hold_rx = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no accepted word on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("FAIL waypoint_range_bearing_top");
            $finish;
        end
    end

    function automatic in_word_t rand_word(bit local_flag, bit wide);
        in_word_t w;
        w.target_x = 16'($urandom);
        w.target_y = 16'($urandom);
        w.current_x = 16'($urandom);
        w.current_y = 16'($urandom);
        w.target_is_local = local_flag;
        if (!wide && $urandom_range(0, 1)) begin
            w.current_x = w.target_x + $signed(16'($urandom_range(0, 64)) - 16'sd32);
            w.current_y = w.target_y + $signed(16'($urandom_range(0, 64)) - 16'sd32);
        end
        return w;
    endfunction

    function automatic in_word_t make_word(logic [15:0] tx, logic [15:0] ty, bit lcl,
                                           logic [15:0] cx, logic [15:0] cy);
        in_word_t w;
        w.target_x = tx; w.target_y = ty; w.target_is_local = lcl;
        w.current_x = cx; w.current_y = cy;
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ORIGIN_X) org_x = val;
        else if (idx == REG_ORIGIN_Y) org_y = val;
        else if (idx == REG_ROTATION) plot_rot = val;
    endtask

    // wait until every expected result is back and the pipe is empty
    task automatic drain();
        wait (pending_words.size() == 0 && !in_valid);
        @(posedge clk);
        while (expected_words.size() > 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_random(int n, bit lcl_mix);
        for (int i = 0; i < n; i++)
            pending_words.push_back(rand_word(lcl_mix ? bit'($urandom_range(0, 1)) : 1'b0,
                                              $urandom_range(0, 3) == 0));
    endtask

    initial
    begin
        org_x = 0; org_y = 0; plot_rot = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero vector, global and local paths
        pending_words.push_back(make_word(16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'h7FFF, 16'h7FFF, 1'b0, 16'h8000, 16'h8000));
        pending_words.push_back(make_word(16'h8000, 16'h8000, 1'b0, 16'h7FFF, 16'h7FFF));
        pending_words.push_back(make_word(16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'h0000, 16'h8000, 1'b0, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'h0000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'h1234, 16'h1234, 1'b1, 16'h1234, 16'h1234));
        pending_words.push_back(make_word(16'hFFFF, 16'h0000, 1'b0, 16'h0000, 16'h0001));
        drain();

        write_reg(REG_ORIGIN_X, 16'h7FFF);
        write_reg(REG_ORIGIN_Y, 16'h8000);
        write_reg(REG_ROTATION, 16'h2000);
        pending_words.push_back(make_word(16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'h8000, 16'h7FFF, 1'b1, 16'h0000, 16'h0000));
        pending_words.push_back(make_word(16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000));
        pending_words.push_back(make_word(16'h0000, 16'h0000, 1'b1, 16'h7FFF, 16'h8000));
        drain();

        // rotations at quadrant edges and the largest code
        begin
            logic [15:0] rots[6];
            rots = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hE000, 16'hFFFF};
            for (int k = 0; k < 6; k++) begin
                write_reg(REG_ROTATION, rots[k]);
                write_reg(REG_ORIGIN_X, 16'($urandom));
                write_reg(REG_ORIGIN_Y, 16'($urandom));
                pending_words.push_back(make_word(16'h1000, 16'h0800, 1'b1, 16'h0000, 16'h0000));
                load_random(60, 1'b1);
                if (k == 2) begin
                    // long receiver hold-off while the sender keeps offering
                    hold_rx = 1;
                end
                drain();
            end
        end

        // origin extremes with random rotation
        write_reg(REG_ORIGIN_X, 16'h8000);
        write_reg(REG_ORIGIN_Y, 16'h7FFF);
        write_reg(REG_ROTATION, 16'($urandom));
        load_random(200, 1'b1);
        drain();
        write_reg(REG_ORIGIN_X, 16'h0000);
        write_reg(REG_ORIGIN_Y, 16'h0000);
        write_reg(REG_ROTATION, 16'($urandom));
        load_random(200, 1'b1);
        drain();

        if (failures == 0)
            $display("PASS waypoint_range_bearing_top");
        else
            $display("FAIL waypoint_range_bearing_top");
        $finish;
    end
endmodule
